>>> hdl/mvs_pkg.sv
// ----------------------------------------------------------------------------
// mvs_pkg
// shared types, request codes and format bytes of the msgpack value serializer
// ----------------------------------------------------------------------------
`default_nettype none

package mvs_pkg;

	// request kinds
	localparam logic [3:0] REQ_NIL    = 4'd0;
	localparam logic [3:0] REQ_BOOL   = 4'd1;
	localparam logic [3:0] REQ_UINT   = 4'd2;
	localparam logic [3:0] REQ_INT    = 4'd3;
	localparam logic [3:0] REQ_FLOAT  = 4'd4;
	localparam logic [3:0] REQ_DOUBLE = 4'd5;
	localparam logic [3:0] REQ_STR    = 4'd6;
	localparam logic [3:0] REQ_ARRAY  = 4'd7;
	localparam logic [3:0] REQ_MAP    = 4'd8;
	localparam logic [3:0] REQ_EXT    = 4'd9;
	localparam logic [3:0] REQ_RAW    = 4'd10;

	// format bytes
	localparam logic [7:0] FMT_NIL      = 8'hc0;
	localparam logic [7:0] FMT_FALSE    = 8'hc2;
	localparam logic [7:0] FMT_TRUE     = 8'hc3;
	localparam logic [7:0] FMT_EXT8     = 8'hc7;
	localparam logic [7:0] FMT_EXT16    = 8'hc8;
	localparam logic [7:0] FMT_EXT32    = 8'hc9;
	localparam logic [7:0] FMT_FLOAT32  = 8'hca;
	localparam logic [7:0] FMT_FLOAT64  = 8'hcb;
	localparam logic [7:0] FMT_UINT8    = 8'hcc;
	localparam logic [7:0] FMT_UINT16   = 8'hcd;
	localparam logic [7:0] FMT_UINT32   = 8'hce;
	localparam logic [7:0] FMT_UINT64   = 8'hcf;
	localparam logic [7:0] FMT_INT8     = 8'hd0;
	localparam logic [7:0] FMT_INT16    = 8'hd1;
	localparam logic [7:0] FMT_INT32    = 8'hd2;
	localparam logic [7:0] FMT_INT64    = 8'hd3;
	localparam logic [7:0] FMT_FIXEXT1  = 8'hd4;
	localparam logic [7:0] FMT_FIXEXT2  = 8'hd5;
	localparam logic [7:0] FMT_FIXEXT4  = 8'hd6;
	localparam logic [7:0] FMT_FIXEXT8  = 8'hd7;
	localparam logic [7:0] FMT_FIXEXT16 = 8'hd8;
	localparam logic [7:0] FMT_STR8     = 8'hd9;
	localparam logic [7:0] FMT_STR16    = 8'hda;
	localparam logic [7:0] FMT_STR32    = 8'hdb;
	localparam logic [7:0] FMT_ARRAY16  = 8'hdc;
	localparam logic [7:0] FMT_ARRAY32  = 8'hdd;
	localparam logic [7:0] FMT_MAP16    = 8'hde;
	localparam logic [7:0] FMT_MAP32    = 8'hdf;
	localparam logic [7:0] FMT_FIXSTR   = 8'ha0;
	localparam logic [7:0] FMT_FIXARRAY = 8'h90;
	localparam logic [7:0] FMT_FIXMAP   = 8'h80;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [3:0]        req_type;
		logic [63:0]       value;
		logic signed [7:0] ext_kind;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} rsp_t;

	// one classified item: optional head byte, 0..8 body bytes, optional tail byte
	typedef struct packed {
		logic        head_vld;
		logic [7:0]  head;
		logic [3:0]  body_n;
		logic [63:0] body;
		logic        tail_vld;
		logic [7:0]  tail;
		logic        big_endian;
	} desc_t;

endpackage

`default_nettype wire

>>> hdl/mvs_front.sv
// ----------------------------------------------------------------------------
// mvs_front
// classifies one request into a head byte, body bytes and a tail byte
// ----------------------------------------------------------------------------
`default_nettype none

module mvs_front (
	input  wire mvs_pkg::req_t  req,
	input  wire logic           big_endian,
	output mvs_pkg::desc_t      desc,
	output logic                desc_vld
);

	logic [63:0] v;
	logic [31:0] c;

	assign v = req.value;
	assign c = req.value[31:0];

	always_comb begin
		desc            = '0;
		desc.big_endian = big_endian;
		desc.tail       = req.ext_kind;
		desc_vld        = 1'b1;
		unique case (req.req_type)
			mvs_pkg::REQ_NIL: begin
				desc.head_vld = 1'b1;
				desc.head     = mvs_pkg::FMT_NIL;
			end
			mvs_pkg::REQ_BOOL: begin
				desc.head_vld = 1'b1;
				desc.head     = (v != 64'd0) ? mvs_pkg::FMT_TRUE : mvs_pkg::FMT_FALSE;
			end
			mvs_pkg::REQ_UINT, mvs_pkg::REQ_INT: begin
				desc.head_vld = 1'b1;
				desc.body     = v;
				if (req.req_type == mvs_pkg::REQ_INT && v[63]) begin
					priority if (&v[63:5]) begin
						desc.head = v[7:0];
					end else if (&v[63:7]) begin
						desc.head = mvs_pkg::FMT_INT8;  desc.body_n = 4'd1;
					end else if (&v[63:15]) begin
						desc.head = mvs_pkg::FMT_INT16; desc.body_n = 4'd2;
					end else if (&v[63:31]) begin
						desc.head = mvs_pkg::FMT_INT32; desc.body_n = 4'd4;
					end else begin
						desc.head = mvs_pkg::FMT_INT64; desc.body_n = 4'd8;
					end
				end else begin
					priority if (v[63:7] == '0) begin
						desc.head = v[7:0];
					end else if (v[63:8] == '0) begin
						desc.head = mvs_pkg::FMT_UINT8;  desc.body_n = 4'd1;
					end else if (v[63:16] == '0) begin
						desc.head = mvs_pkg::FMT_UINT16; desc.body_n = 4'd2;
					end else if (v[63:32] == '0) begin
						desc.head = mvs_pkg::FMT_UINT32; desc.body_n = 4'd4;
					end else begin
						desc.head = mvs_pkg::FMT_UINT64; desc.body_n = 4'd8;
					end
				end
			end
			mvs_pkg::REQ_FLOAT: begin
				desc.head_vld = 1'b1;
				desc.head     = mvs_pkg::FMT_FLOAT32;
				desc.body     = {32'd0, c};
				desc.body_n   = 4'd4;
			end
			mvs_pkg::REQ_DOUBLE: begin
				desc.head_vld = 1'b1;
				desc.head     = mvs_pkg::FMT_FLOAT64;
				desc.body     = v;
				desc.body_n   = 4'd8;
			end
			mvs_pkg::REQ_STR: begin
				desc.head_vld = 1'b1;
				desc.body     = {32'd0, c};
				priority if (c[31:5] == '0) begin
					desc.head = mvs_pkg::FMT_FIXSTR | {3'd0, c[4:0]};
				end else if (c[31:8] == '0) begin
					desc.head = mvs_pkg::FMT_STR8;  desc.body_n = 4'd1;
				end else if (c[31:16] == '0) begin
					desc.head = mvs_pkg::FMT_STR16; desc.body_n = 4'd2;
				end else begin
					desc.head = mvs_pkg::FMT_STR32; desc.body_n = 4'd4;
				end
			end
			mvs_pkg::REQ_ARRAY, mvs_pkg::REQ_MAP: begin
				desc.head_vld = 1'b1;
				desc.body     = {32'd0, c};
				priority if (c[31:4] == '0) begin
					desc.head = ((req.req_type == mvs_pkg::REQ_MAP) ? mvs_pkg::FMT_FIXMAP
						: mvs_pkg::FMT_FIXARRAY) | {4'd0, c[3:0]};
				end else if (c[31:16] == '0) begin
					desc.head   = (req.req_type == mvs_pkg::REQ_MAP) ? mvs_pkg::FMT_MAP16
						: mvs_pkg::FMT_ARRAY16;
					desc.body_n = 4'd2;
				end else begin
					desc.head   = (req.req_type == mvs_pkg::REQ_MAP) ? mvs_pkg::FMT_MAP32
						: mvs_pkg::FMT_ARRAY32;
					desc.body_n = 4'd4;
				end
			end
			mvs_pkg::REQ_EXT: begin
				desc.tail_vld = 1'b1;
				desc.body     = v;
				desc.head_vld = 1'b1;
				priority if (v == 64'd0) begin
					desc_vld      = 1'b0;
					desc.head_vld = 1'b0;
				end else if (v == 64'd1) begin
					desc.head = mvs_pkg::FMT_FIXEXT1;
				end else if (v == 64'd2) begin
					desc.head = mvs_pkg::FMT_FIXEXT2;
				end else if (v == 64'd4) begin
					desc.head = mvs_pkg::FMT_FIXEXT4;
				end else if (v == 64'd8) begin
					desc.head = mvs_pkg::FMT_FIXEXT8;
				end else if (v == 64'd16) begin
					desc.head = mvs_pkg::FMT_FIXEXT16;
				end else if (v[63:8] == '0) begin
					desc.head = mvs_pkg::FMT_EXT8;  desc.body_n = 4'd1;
				end else if (v[63:16] == '0) begin
					desc.head = mvs_pkg::FMT_EXT16; desc.body_n = 4'd2;
				end else if (v[63:32] == '0) begin
					desc.head = mvs_pkg::FMT_EXT32; desc.body_n = 4'd4;
				end else begin
					// oversized length: type code only
					desc.head_vld = 1'b0;
				end
			end
			mvs_pkg::REQ_RAW: begin
				desc.head_vld = 1'b1;
				desc.head     = v[7:0];
			end
			default: begin
				desc_vld = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/mvs_queue.sv
// ----------------------------------------------------------------------------
// mvs_queue
// short descriptor queue between classifier and byte emitter
// ----------------------------------------------------------------------------
`default_nettype none

module mvs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mvs_pkg::desc_t push_desc,
	output logic                full,
	input  wire logic           pop,
	output logic                head_vld,
	output mvs_pkg::desc_t      head_desc
);

	localparam int PTR_W = $clog2(mvs_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mvs_pkg::QUEUE_DEPTH + 1);

	mvs_pkg::desc_t     entry_q [mvs_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(mvs_pkg::QUEUE_DEPTH));
	assign head_vld  = (count_q != '0);
	assign head_desc = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(mvs_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(mvs_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_vld)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hdl/mvs_back.sv
// ----------------------------------------------------------------------------
// mvs_back
// byte emitter: walks one descriptor a byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mvs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           desc_vld,
	input  wire mvs_pkg::desc_t desc,
	output logic                pop,
	output logic                rsp_valid,
	output mvs_pkg::rsp_t       rsp
);

	mvs_pkg::desc_t cur_q;
	logic           active_q;
	logic [3:0]     pos_q;

	logic [3:0]  total;
	logic [3:0]  body_pos;
	logic [3:0]  body_rev;
	logic [2:0]  idx;
	logic [63:0] shifted;
	logic        is_last;
	logic        load;

	assign total    = {3'd0, cur_q.head_vld} + cur_q.body_n + {3'd0, cur_q.tail_vld};
	assign body_pos = pos_q - {3'd0, cur_q.head_vld};
	assign body_rev = cur_q.body_n - 4'd1 - body_pos;
	assign idx      = cur_q.big_endian ? body_rev[2:0] : body_pos[2:0];
	assign shifted  = cur_q.body >> {idx, 3'b000};
	assign is_last  = (pos_q == total - 4'd1);

	always_comb begin
		rsp.last = is_last;
		priority if (cur_q.head_vld && pos_q == 4'd0) begin
			rsp.out_byte = cur_q.head;
		end else if (body_pos < cur_q.body_n) begin
			rsp.out_byte = shifted[7:0];
		end else begin
			rsp.out_byte = cur_q.tail;
		end
	end

	assign rsp_valid = active_q;
	assign load      = !active_q || is_last;
	assign pop       = load && desc_vld;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
		end else if (load) begin
			active_q <= desc_vld;
			pos_q    <= '0;
		end else begin
			pos_q <= pos_q + 4'd1;
		end
	end

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> pos_q < total)
		else $error("byte position beyond descriptor");

	a_walk_advances: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !is_last |=> active_q && pos_q == $past(pos_q) + 4'd1)
		else $error("emitter left an item before its last byte");

endmodule

`default_nettype wire

>>> hdl/msgpack_value_serializer.sv
// ----------------------------------------------------------------------------
// msgpack_value_serializer
// turns one typed value per request into its messagepack byte sequence
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Its
// encoding leaves on rsp, one byte per cycle with rsp_valid high for exactly
// that cycle, the final byte of the request flagged by rsp.last; the receiver
// cannot stall, so every strobed byte must be taken. A request that encodes
// to k bytes (1 to 9) holds the byte emitter until its k bytes are out, and
// the emitter loads the next item under the last byte; with the emitter idle,
// a taken request passes through a queue entry and then the emitter's
// descriptor register before its first byte is driven. Requests are
// classified on entry and parked in a two-entry queue, so start may be
// pulsed every cycle until the queue fills, and busy rises only while both
// entries wait. Requests that encode to nothing (ext of length zero, unused
// kinds) are taken and dropped. The byte-order register is written over the
// cfg channel (cfg_ready is always high) and should only change while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_value_serializer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// request side
	input  wire logic          start,
	output logic               busy,
	input  wire mvs_pkg::req_t req,
	// byte stream
	output logic               rsp_valid,
	output mvs_pkg::rsp_t      rsp,
	// byte-order register write
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [0:0]    cfg_data
);

	logic           big_endian_q;
	mvs_pkg::desc_t front_desc;
	logic           front_vld;
	logic           q_full;
	logic           push;
	logic           pop;
	logic           q_vld;
	mvs_pkg::desc_t q_desc;

	// register write completes in the cycle it is offered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			big_endian_q <= cfg_data[0];
		end
	end

	// request transfer; items with no bytes are swallowed here
	assign busy = q_full;
	assign push = start && !busy && front_vld;

	// front: classification into head / body / tail
	mvs_front u_front (
		.req        (req),
		.big_endian (big_endian_q),
		.desc       (front_desc),
		.desc_vld   (front_vld)
	);

	// decoupling queue
	mvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (front_desc),
		.full      (q_full),
		.pop       (pop),
		.head_vld  (q_vld),
		.head_desc (q_desc)
	);

	// back: one byte per cycle, next item loaded under the last byte
	mvs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_vld  (q_vld),
		.desc      (q_desc),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_busy_only_when_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> rsp_valid)
		else $error("busy with nothing being emitted");

endmodule

`default_nettype wire
